@@ design/smt_pkg.sv @@
// Shared constants and controller/datapath interface types for the sliding median block.
package smt_pkg;

	// Number of timestamps the window holds.
	localparam int WINDOW = 11;

	// Slot index width and fill count width, derived from the window depth.
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);

	// Field widths on the streams.
	localparam int TIME_W = 32;
	localparam int HELD_W = 4;
	localparam int OUT_W  = 40;

	// Action codes carried in the input tuser.
	localparam logic ACT_APPEND = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store;     // input transfer: append if asked, restart the rank pass
		logic scan_step; // rank one candidate slot and advance
		logic load_out;  // move the median and count into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last; // the candidate being ranked is the last slot
	} stat_t;

endpackage

@@ design/sliding_median_timestamp.sv @@
// Top level of the sliding-window median of block timestamps.
//
// Channel  Dir  Bits (low to high)                    Transfer
// s_*      in   tdata: block_time[31:0]; tuser: action  s_tvalid & s_tready
// m_*      out  tdata: median_time[31:0], held_count[35:32], zero[39:36]
//                                                       m_tvalid & m_tready
//
// Each item runs through the transfer cycle, a rank pass over the held entries
// at one window slot per cycle, and the load of the output register. The rank
// pass compares one candidate slot against all slots each cycle. Reset clears
// the window count and pointers; no clearing pass.
// A result waiting in the output register holds the block in its final load cycle,
// and the input is not ready again until that load is done.
module sliding_median_timestamp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [smt_pkg::TIME_W-1:0] s_tdata,  // block_time
	input  logic [0:0]                s_tuser,  // action
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [smt_pkg::OUT_W-1:0]  m_tdata   // median_time, held_count, zero fill
);
	import smt_pkg::*;

	cmd_t              cmd;
	stat_t             stat;
	logic [TIME_W-1:0] median_time;
	logic [HELD_W-1:0] held_count;

	// Sequencing and handshakes.
	smt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// Window storage and rank pass.
	smt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.action      (s_tuser[0]),
		.block_time  (s_tdata),
		.median_time (median_time),
		.held_count  (held_count)
	);

	// Pack the result fields, zero fill to whole bytes.
	assign m_tdata = {{(OUT_W - TIME_W - HELD_W){1'b0}}, held_count, median_time};

endmodule

@@ design/smt_dp.sv @@
// Datapath of the sliding median block: timestamp ring, rank pass and output register.
module smt_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  smt_pkg::cmd_t              cmd,
	output smt_pkg::stat_t             stat,
	input  logic                       action,
	input  logic [smt_pkg::TIME_W-1:0] block_time,
	output logic [smt_pkg::TIME_W-1:0] median_time,
	output logic [smt_pkg::HELD_W-1:0] held_count
);
	import smt_pkg::*;

	logic [TIME_W-1:0] win_q [WINDOW];
	logic [SLOT_W-1:0] oldest_q;
	logic [CNT_W-1:0]  fill_q;
	logic [SLOT_W-1:0] cand_q;
	logic [TIME_W-1:0] med_q;
	logic [TIME_W-1:0] out_med_q;
	logic [HELD_W-1:0] out_cnt_q;

	logic              full;
	logic [TIME_W-1:0] cand_val;
	logic [WINDOW-1:0] lt_vec;
	logic [WINDOW-1:0] le_vec;
	logic [CNT_W-1:0]  lt_cnt;
	logic [CNT_W-1:0]  le_cnt;
	logic [CNT_W-1:0]  mid_idx;
	logic              cand_valid;
	logic              cand_hit;
	logic [CNT_W+HELD_W-1:0] fill_ext;

	assign full = (fill_q == CNT_W'(WINDOW));

	// Timestamp ring: fills slots from zero, then overwrites the oldest slot.
	always_ff @(posedge clk) begin
		if (cmd.store && action == ACT_APPEND) begin
			if (full) begin
				win_q[oldest_q] <= block_time;
			end else begin
				win_q[fill_q[SLOT_W-1:0]] <= block_time;
			end
		end
	end

	// Ring pointers. The oldest slot only moves once the window is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			fill_q   <= '0;
		end else if (cmd.store && action == ACT_APPEND) begin
			if (full) begin
				if (oldest_q == SLOT_W'(WINDOW - 1)) begin
					oldest_q <= '0;
				end else begin
					oldest_q <= oldest_q + SLOT_W'(1);
				end
			end else begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

	// Rank the candidate slot against every held entry in parallel. Held slots are
	// those below the fill count, since the ring starts at slot zero until full.
	always_comb begin
		cand_val = win_q[cand_q];
		for (int j = 0; j < WINDOW; j++) begin
			lt_vec[j] = (CNT_W'(j) < fill_q) && (win_q[j] < cand_val);
			le_vec[j] = (CNT_W'(j) < fill_q) && (win_q[j] <= cand_val);
		end
		lt_cnt     = CNT_W'($countones(lt_vec));
		le_cnt     = CNT_W'($countones(le_vec));
		mid_idx    = fill_q >> 1;
		cand_valid = ({1'b0, cand_q} < {1'b0, fill_q});
		cand_hit   = cand_valid && (lt_cnt <= mid_idx) && (mid_idx < le_cnt);
	end

	// Candidate counter, restarted by each input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else if (cmd.store) begin
			cand_q <= '0;
		end else if (cmd.scan_step) begin
			cand_q <= cand_q + SLOT_W'(1);
		end
	end

	assign stat.scan_last = (cand_q == SLOT_W'(WINDOW - 1));

	// Median capture: zero for an empty window, else the candidate whose rank spans the middle.
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			med_q <= '0;
		end else if (cmd.scan_step && cand_hit) begin
			med_q <= cand_val;
		end
	end

	assign fill_ext = {{HELD_W{1'b0}}, fill_q};

	// Output register, loaded once the rank pass is done.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_med_q <= med_q;
			out_cnt_q <= fill_ext[HELD_W-1:0];
		end
	end

	assign median_time = out_med_q;
	assign held_count  = out_cnt_q;

`ifndef SYNTHESIS
	// The fill count never exceeds the window depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW))
		else $error("fill count beyond window depth");

	// The oldest slot moves only after the window has filled.
	a_oldest_full: assert property (@(posedge clk) disable iff (!arst_n)
		(oldest_q != '0) |-> full)
		else $error("oldest slot moved before the window was full");

	// An append to a partly filled window raises the count by one.
	a_fill_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.store && action == ACT_APPEND && !full) |=> (fill_q == $past(fill_q) + CNT_W'(1)))
		else $error("append did not raise the fill count");
`endif

endmodule

@@ design/smt_ctrl.sv @@
// Controller of the sliding median block: handshakes and rank pass sequencing.
module smt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output smt_pkg::cmd_t  cmd,
	input  smt_pkg::stat_t stat
);
	import smt_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       m_tvalid_q;
	logic       out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// Next state and commands.
	always_comb begin
		state_d       = state_q;
		cmd.store     = 1'b0;
		cmd.scan_step = 1'b0;
		cmd.load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.store = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output valid flag: set on load, cleared when the result transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;

`ifndef SYNTHESIS
	// A pending result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_tvalid_q || m_tready))
		else $error("result register loaded while a result was pending");

	// No second input transfer is taken while an item is in work.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted during a rank pass");

	// The rank pass ends on the last slot and then delivers.
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && stat.scan_last) |=> (state_q == ST_FIN))
		else $error("rank pass did not end at the last slot");
`endif

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the sliding-window median of block timestamps.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import smt_pkg::*;

	localparam int ITEMS      = 1850;
	localparam int HOLD_LEN   = 300;
	localparam int IDLE_LIMIT = 4000;
	localparam int TAIL       = 30;

	// Mirror of the block: holds the window and the queue of results still owed.
	class median_board;
		logic [TIME_W-1:0] ring [WINDOW];
		int unsigned       oldest;
		int unsigned       fill;
		logic [TIME_W-1:0] median_q [$];
		logic [HELD_W-1:0] held_q [$];
		int unsigned       errors;
		int unsigned       results;
		int unsigned       appends;
		int unsigned       evictions;
		int unsigned       queries;
		int unsigned       empty_queries;

		function new();
			oldest        = 0;
			fill          = 0;
			errors        = 0;
			results       = 0;
			appends       = 0;
			evictions     = 0;
			queries       = 0;
			empty_queries = 0;
		endfunction

		function int unsigned pending();
			return median_q.size();
		endfunction

		// Pick the held value whose rank range covers index fill/2.
		function logic [TIME_W-1:0] window_median();
			logic [TIME_W-1:0] vals [WINDOW];
			int unsigned       k;
			int unsigned       below;
			int unsigned       same;
			if (fill == 0)
				return '0;
			for (int i = 0; i < fill; i++)
				vals[i] = ring[(oldest + i) % WINDOW];
			k = fill / 2;
			for (int i = 0; i < fill; i++) begin
				below = 0;
				same  = 0;
				for (int j = 0; j < fill; j++) begin
					if (vals[j] < vals[i])
						below++;
					else if (vals[j] == vals[i])
						same++;
				end
				if (below <= k && k < below + same)
					return vals[i];
			end
			return '0;
		endfunction

		// Update the window for one accepted input transfer and queue its result.
		function void note_input(logic act, logic [TIME_W-1:0] stamp);
			if (act == ACT_APPEND) begin
				appends++;
				if (fill < WINDOW) begin
					ring[(oldest + fill) % WINDOW] = stamp;
					fill++;
				end else begin
					ring[oldest] = stamp;
					oldest = (oldest + 1) % WINDOW;
					evictions++;
				end
			end else begin
				queries++;
				if (fill == 0)
					empty_queries++;
			end
			median_q = {median_q, window_median()};
			held_q   = {held_q, HELD_W'(fill)};
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= 40)
				$display("MISMATCH at %0t ns: %s", $realtime, msg);
		endtask

		// Compare one output transfer with the oldest owed result.
		task check_result(input logic [OUT_W-1:0] word);
			logic [TIME_W-1:0] want_median;
			logic [HELD_W-1:0] want_held;
			results++;
			if (median_q.size() == 0) begin
				report($sformatf("result %h arrived with none owed", word));
				return;
			end
			want_median = median_q.pop_front();
			want_held   = held_q.pop_front();
			if (word[TIME_W-1:0] !== want_median)
				report($sformatf("median_time %h, expected %h", word[TIME_W-1:0], want_median));
			if (word[TIME_W +: HELD_W] !== want_held)
				report($sformatf("held_count %0d, expected %0d", word[TIME_W +: HELD_W],
					want_held));
			if (word[OUT_W-1:TIME_W+HELD_W] !== '0)
				report($sformatf("fill bits %b are not zero", word[OUT_W-1:TIME_W+HELD_W]));
		endtask
	endclass

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [TIME_W-1:0] s_tdata  = '0;
	logic [0:0]        s_tuser  = ACT_APPEND;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	median_board board;
	int unsigned sent      = 0;
	int unsigned holds     = 0;
	int unsigned idle_run  = 0;
	bit          hold_req  = 1'b0;
	bit          steady    = 1'b0;

	sliding_median_timestamp i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// Offer one item and wait for its transfer; valid stays high for a following item.
	task automatic send_stamp(input logic act, input logic [TIME_W-1:0] stamp);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= stamp;
		do @(posedge clk); while (!s_tready);
		board.note_input(act, stamp);
		sent++;
	endtask

	task automatic idle_gap(input int unsigned cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stop offering until every owed result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// Result side: check transfers, then choose ready for the next edge.
	always @(posedge clk) begin
		int unsigned hold_left;
		if (m_tvalid && m_tready)
			board.check_result(m_tdata);
		if (hold_req && hold_left == 0) begin
			hold_left = HOLD_LEN;
			hold_req  = 1'b0;
			holds++;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (steady || !arst_n) begin
			m_tready <= arst_n;
		end else begin
			m_tready <= ($urandom_range(99) >= 21);
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results owed", idle_run,
				board.pending());
			$display("sliding_median_timestamp regression: fail");
			$finish;
		end
	end

	initial begin
		int unsigned       mode;
		int unsigned       burst;
		logic [TIME_W-1:0] stamp;
		logic [TIME_W-1:0] base;
		logic              act;

		board = new();
		base  = $urandom;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty window, field extremes, upper middle, duplicates, eviction.
		send_stamp(ACT_QUERY, 32'hFFFF_FFFF);
		send_stamp(ACT_APPEND, 32'h0000_0000);
		send_stamp(ACT_QUERY, 32'h0000_0000);
		send_stamp(ACT_APPEND, 32'hFFFF_FFFF);
		send_stamp(ACT_APPEND, 32'h0000_0001);
		send_stamp(ACT_APPEND, 32'h8000_0000);
		send_stamp(ACT_APPEND, 32'h0000_0005);
		send_stamp(ACT_APPEND, 32'h0000_0005);
		send_stamp(ACT_APPEND, 32'h0000_0005);
		send_stamp(ACT_APPEND, 32'h7FFF_FFFF);
		send_stamp(ACT_APPEND, 32'hAAAA_AAAA);
		send_stamp(ACT_APPEND, 32'h5555_5555);
		send_stamp(ACT_APPEND, 32'hFFFF_FFFE);
		send_stamp(ACT_QUERY, 32'h1234_5678);
		for (int i = 0; i < 9; i++)
			send_stamp(ACT_APPEND, 32'h6000_0000 - 32'(i) * 32'h0100_0000);
		send_stamp(ACT_QUERY, 32'h0000_0000);
		drain_results();

		// Random bursts: realistic rising timestamps, full-range noise, heavy
		// duplicates and values near the top of the range.
		while (sent < ITEMS) begin
			mode  = $urandom_range(3);
			burst = $urandom_range(40, 1);
			repeat (burst) begin
				case (mode)
					0: stamp = $urandom;
					1: begin
						base  = base + $urandom_range(1200);
						stamp = base - $urandom_range(300);
					end
					2: stamp = $urandom_range(7);
					default: stamp = 32'hFFFF_FFFF - $urandom_range(7);
				endcase
				act    = ($urandom_range(99) < 15) ? ACT_QUERY : ACT_APPEND;
				steady = (sent >= 700 && sent < 1000);
				if (sent == 400 || sent == 1400)
					hold_req = 1'b1;
				send_stamp(act, stamp);
				if (sent == 1200)
					drain_results();
				else if (!steady && $urandom_range(99) < 21)
					idle_gap($urandom_range(6, 1));
			end
		end

		drain_results();
		repeat (TAIL) @(posedge clk);

		$display("Covered %0d appends (%0d evicting the oldest) and %0d queries (%0d on empty).",
			board.appends, board.evictions, board.queries, board.empty_queries);
		$display("Checked %0d results across %0d long result-side hold-offs; %0d mismatches.",
			board.results, holds, board.errors);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("sliding_median_timestamp regression: pass");
		end else begin
			$display("sliding_median_timestamp regression: fail");
		end
		$finish;
	end

endmodule
